// ===== rtl/lsrc_pkg.sv =====
// Shared types and constants for the line segment rectangle clipper.
package lsrc_pkg;

	// Coordinate, difference and product widths inside the datapath
	localparam int CRD_W = 18;
	localparam int DIF_W = 19;
	localparam int PRD_W = 40;
	localparam int IN_W  = 16;
	localparam int MAX_W = 15;

	// Divider operand widths: quotient is always a clipped coordinate
	localparam int NUM_W = 34;
	localparam int DEN_W = 18;
	localparam int QUO_W = MAX_W;

	// Configuration register indexes
	localparam logic [0:0] REG_CLIP_X_MAX = 1'b0;
	localparam logic [0:0] REG_CLIP_Y_MAX = 1'b1;

	localparam logic [MAX_W-1:0] CLIP_MAX_RST = 15'd1023;

	typedef logic signed [CRD_W-1:0] crd_t;
	typedef logic signed [DIF_W-1:0] diff_t;
	typedef logic signed [PRD_W-1:0] prod_t;

	// One division: n / d, n >= 0, d > 0
	typedef struct packed {
		logic [NUM_W-1:0] n;
		logic [DEN_W-1:0] d;
	} div_in_t;

	// Work handed from the geometry stages to the dividers
	typedef struct packed {
		logic    visible;
		div_in_t sx;
		div_in_t sy;
		div_in_t ex;
		div_in_t ey;
	} clip_job_t;

endpackage

// ===== rtl/lsrc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module lsrc_div import lsrc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  div_in_t          op,
	output logic [QUO_W-1:0] quo
);

	logic [NUM_W-1:0] rem_s [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];

	assign rem_s[0] = op.n;
	assign den_s[0] = op.d;
	assign quo_s[0] = '0;

	// Each stage resolves one quotient bit, MSB first
	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		localparam int B = QUO_W - 1 - i;
		logic [NUM_W-1:0] trial;
		logic             ge;

		assign trial = NUM_W'(den_s[i]) << B;
		assign ge    = rem_s[i] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? rem_s[i] - trial : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= {quo_s[i][QUO_W-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QUO_W];

endmodule

// ===== rtl/lsrc_front.sv =====
// Geometry stages: decode, order, reject, edge cuts and divider setup.
module lsrc_front import lsrc_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [IN_W-1:0]  start_x,
	input  logic [IN_W-1:0]  start_y,
	input  logic [IN_W-1:0]  end_x,
	input  logic [IN_W-1:0]  end_y,
	input  logic [MAX_W-1:0] clip_x_max,
	input  logic [MAX_W-1:0] clip_y_max,
	output logic             job_vld,
	output clip_job_t        job
);

	localparam int IN_SW = (COORD_WIDTH < IN_W) ? COORD_WIDTH : IN_W;
	localparam logic [CRD_W-1:0] IN_MASK = (CRD_W'(1) << IN_SW) - CRD_W'(1);
	localparam bit IN_SIGNED = (COORD_WIDTH <= IN_W);

	function automatic crd_t decode(input logic [IN_W-1:0] f);
		logic [CRD_W-1:0] m;
		m = {{(CRD_W-IN_W){1'b0}}, f} & IN_MASK;
		if (IN_SIGNED && m[IN_SW-1])
			m = m | ~IN_MASK;
		return $signed(m);
	endfunction

	crd_t  xm, ym;
	assign xm = $signed({{(CRD_W-MAX_W){1'b0}}, clip_x_max});
	assign ym = $signed({{(CRD_W-MAX_W){1'b0}}, clip_y_max});

	// Stage 1: decode and order endpoints
	crd_t ax_d, ay_d, bx_d, by_d;
	logic hz_d, vt_d, swap_d;
	assign ax_d   = decode(start_x);
	assign ay_d   = decode(start_y);
	assign bx_d   = decode(end_x);
	assign by_d   = decode(end_y);
	assign hz_d   = ay_d == by_d;
	assign vt_d   = (ax_d == bx_d) && !hz_d;
	assign swap_d = vt_d ? (by_d < ay_d) : (bx_d < ax_d);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	crd_t ax_s1, ay_s1, bx_s1, by_s1;
	logic hv_s1, hz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= swap_d ? bx_d : ax_d;
			ay_s1 <= swap_d ? by_d : ay_d;
			bx_s1 <= swap_d ? ax_d : bx_d;
			by_s1 <= swap_d ? ay_d : by_d;
			hv_s1 <= hz_d || vt_d;
			hz_s1 <= hz_d;
		end
	end

	// Stage 2: trivial reject, deltas, clamps for axis-aligned segments
	crd_t ax_s2, ay_s2, bx_s2;
	diff_t dx_s2, dy_s2;
	logic rej_s2, hv_s2, pcut_s2, qcut_s2;
	logic [MAX_W-1:0] d0x_s2, d0y_s2, d1x_s2, d1y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			bx_s2   <= bx_s1;
			dx_s2   <= diff_t'(bx_s1) - diff_t'(ax_s1);
			dy_s2   <= diff_t'(by_s1) - diff_t'(ay_s1);
			rej_s2  <= (bx_s1 < 0) || (ax_s1 > xm) || ((ay_s1 < 0) && (by_s1 < 0))
				|| ((ay_s1 > ym) && (by_s1 > ym));
			hv_s2   <= hv_s1;
			pcut_s2 <= ax_s1 < 0;
			qcut_s2 <= bx_s1 > xm;
			if (hz_s1) begin
				d0x_s2 <= (ax_s1 < 0) ? '0 : ax_s1[MAX_W-1:0];
				d1x_s2 <= (bx_s1 > xm) ? clip_x_max : bx_s1[MAX_W-1:0];
				d0y_s2 <= ay_s1[MAX_W-1:0];
				d1y_s2 <= by_s1[MAX_W-1:0];
			end else begin
				d0x_s2 <= ax_s1[MAX_W-1:0];
				d1x_s2 <= bx_s1[MAX_W-1:0];
				d0y_s2 <= (ay_s1 < 0) ? '0 : ay_s1[MAX_W-1:0];
				d1y_s2 <= (by_s1 > ym) ? clip_y_max : by_s1[MAX_W-1:0];
			end
		end
	end

	// Stage 3: products
	logic signed [CRD_W+DIF_W-1:0] aydx_m, axdy_m, xdy_m, ydx_m;
	assign aydx_m = ay_s2 * dx_s2;
	assign axdy_m = ax_s2 * dy_s2;
	assign xdy_m  = xm * dy_s2;
	assign ydx_m  = ym * dx_s2;

	prod_t aydx_s3, axdy_s3, xdy_s3, ydx_s3;
	crd_t ax_s3, ay_s3, bx_s3;
	diff_t dx_s3, dy_s3;
	logic rej_s3, hv_s3, pcut_s3, qcut_s3;
	logic [MAX_W-1:0] d0x_s3, d0y_s3, d1x_s3, d1y_s3;
	crd_t by_s2, by_s3;

	always_ff @(posedge clk) begin
		if (en)
			by_s2 <= by_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aydx_s3 <= prod_t'(aydx_m);
			axdy_s3 <= prod_t'(axdy_m);
			xdy_s3  <= prod_t'(xdy_m);
			ydx_s3  <= prod_t'(ydx_m);
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			bx_s3   <= bx_s2;
			by_s3   <= by_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			rej_s3  <= rej_s2;
			hv_s3   <= hv_s2;
			pcut_s3 <= pcut_s2;
			qcut_s3 <= qcut_s2;
			d0x_s3  <= d0x_s2;
			d0y_s3  <= d0y_s2;
			d1x_s3  <= d1x_s2;
			d1y_s3  <= d1y_s2;
		end
	end

	// Stage 4: cross term C = ay*dx - ax*dy
	prod_t c_s4, xdy_s4, ydx_s4;
	crd_t ax_s4, ay_s4, bx_s4, by_s4;
	diff_t dx_s4, dy_s4;
	logic rej_s4, hv_s4, pcut_s4, qcut_s4;
	logic [MAX_W-1:0] d0x_s4, d0y_s4, d1x_s4, d1y_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4    <= aydx_s3 - axdy_s3;
			xdy_s4  <= xdy_s3;
			ydx_s4  <= ydx_s3;
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
			bx_s4   <= bx_s3;
			by_s4   <= by_s3;
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			rej_s4  <= rej_s3;
			hv_s4   <= hv_s3;
			pcut_s4 <= pcut_s3;
			qcut_s4 <= qcut_s3;
			d0x_s4  <= d0x_s3;
			d0y_s4  <= d0y_s3;
			d1x_s4  <= d1x_s3;
			d1y_s4  <= d1y_s3;
		end
	end

	// Stage 5: left/right cuts and top/bottom cut candidates
	logic dyneg;
	assign dyneg = dy_s4 < 0;

	prod_t pxn_s5, pyn_s5, qxn_s5, qyn_s5, nlo_s5, nhi_s5, xlim_s5, ydx_s5;
	diff_t dx_s5, ady_s5;
	logic pyd_s5, qyd_s5, rej_s5, hv_s5;
	logic [MAX_W-1:0] d0x_s5, d0y_s5, d1x_s5, d1y_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			pxn_s5  <= pcut_s4 ? '0 : prod_t'(ax_s4);
			pyn_s5  <= pcut_s4 ? c_s4 : prod_t'(ay_s4);
			pyd_s5  <= pcut_s4;
			qxn_s5  <= qcut_s4 ? prod_t'(xm) : prod_t'(bx_s4);
			qyn_s5  <= qcut_s4 ? c_s4 + xdy_s4 : prod_t'(by_s4);
			qyd_s5  <= qcut_s4;
			nlo_s5  <= dyneg ? c_s4 : -c_s4;
			nhi_s5  <= dyneg ? c_s4 - ydx_s4 : ydx_s4 - c_s4;
			xlim_s5 <= dyneg ? -xdy_s4 : xdy_s4;
			ydx_s5  <= ydx_s4;
			dx_s5   <= dx_s4;
			ady_s5  <= dyneg ? -dy_s4 : dy_s4;
			rej_s5  <= rej_s4;
			hv_s5   <= hv_s4;
			d0x_s5  <= d0x_s4;
			d0y_s5  <= d0y_s4;
			d1x_s5  <= d1x_s4;
			d1y_s5  <= d1y_s4;
		end
	end

	// Stage 6: move points that fall off the top or bottom edge
	logic pbel, pabv, qbel, qabv;
	assign pbel = pyn_s5 < 0;
	assign pabv = pyn_s5 > (pyd_s5 ? ydx_s5 : prod_t'(ym));
	assign qbel = qyn_s5 < 0;
	assign qabv = qyn_s5 > (qyd_s5 ? ydx_s5 : prod_t'(ym));

	prod_t pxn_s6, pyn_s6, qxn_s6, qyn_s6, xlim_s6;
	logic pxd_s6, pyd_s6, qxd_s6, qyd_s6, rej_s6, hv_s6;
	diff_t dx_s6, ady_s6;
	logic [MAX_W-1:0] d0x_s6, d0y_s6, d1x_s6, d1y_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pxn_s6  <= pbel ? nlo_s5 : (pabv ? nhi_s5 : pxn_s5);
			pyn_s6  <= pbel ? '0 : (pabv ? prod_t'(ym) : pyn_s5);
			pxd_s6  <= pbel || pabv;
			pyd_s6  <= pyd_s5 && !(pbel || pabv);
			qxn_s6  <= qbel ? nlo_s5 : (qabv ? nhi_s5 : qxn_s5);
			qyn_s6  <= qbel ? '0 : (qabv ? prod_t'(ym) : qyn_s5);
			qxd_s6  <= qbel || qabv;
			qyd_s6  <= qyd_s5 && !(qbel || qabv);
			xlim_s6 <= xlim_s5;
			dx_s6   <= dx_s5;
			ady_s6  <= ady_s5;
			rej_s6  <= rej_s5;
			hv_s6   <= hv_s5;
			d0x_s6  <= d0x_s5;
			d0y_s6  <= d0y_s5;
			d1x_s6  <= d1x_s5;
			d1y_s6  <= d1y_s5;
		end
	end

	// Stage 7: corner reject and divider operands
	logic pin, qin, vis;
	logic [DEN_W-1:0] one_d, dx_d, ady_d;
	assign pin   = (pxn_s6 >= 0) && (pxn_s6 <= (pxd_s6 ? xlim_s6 : prod_t'(xm)));
	assign qin   = (qxn_s6 >= 0) && (qxn_s6 <= (qxd_s6 ? xlim_s6 : prod_t'(xm)));
	assign vis   = !rej_s6 && (hv_s6 || (pin && qin));
	assign one_d = DEN_W'(1);
	assign dx_d  = DEN_W'(dx_s6);
	assign ady_d = DEN_W'(ady_s6);

	clip_job_t job_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			job_s7.visible <= vis;
			if (!vis) begin
				job_s7.sx <= '{n: '0, d: one_d};
				job_s7.sy <= '{n: '0, d: one_d};
				job_s7.ex <= '{n: '0, d: one_d};
				job_s7.ey <= '{n: '0, d: one_d};
			end else if (hv_s6) begin
				job_s7.sx <= '{n: NUM_W'(d0x_s6), d: one_d};
				job_s7.sy <= '{n: NUM_W'(d0y_s6), d: one_d};
				job_s7.ex <= '{n: NUM_W'(d1x_s6), d: one_d};
				job_s7.ey <= '{n: NUM_W'(d1y_s6), d: one_d};
			end else begin
				job_s7.sx <= '{n: pxn_s6[NUM_W-1:0], d: pxd_s6 ? ady_d : one_d};
				job_s7.sy <= '{n: pyn_s6[NUM_W-1:0], d: pyd_s6 ? dx_d : one_d};
				job_s7.ex <= '{n: qxn_s6[NUM_W-1:0], d: qxd_s6 ? ady_d : one_d};
				job_s7.ey <= '{n: qyn_s6[NUM_W-1:0], d: qyd_s6 ? dx_d : one_d};
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign job_vld = vld_s7;
	assign job     = job_s7;

endmodule

// ===== rtl/line_segment_rect_clip.sv =====
// Throughput: one segment per cycle while item_stall is low; the path runs
// through 7 geometry stages, then 15 divider stages (one quotient bit each),
// then the output register with a one-beat skid.
// A stalled output freezes the pipeline only once the skid is full.
// Reset (arst_n low, asynchronous): all valid bits clear, clip_x_max and
// clip_y_max return to 1023.
module line_segment_rect_clip import lsrc_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [IN_W-1:0]  start_x,
	input  logic [IN_W-1:0]  start_y,
	input  logic [IN_W-1:0]  end_x,
	input  logic [IN_W-1:0]  end_y,
	output logic             res_valid,
	input  logic             res_stall,
	output logic             visible,
	output logic [MAX_W-1:0] out_start_x,
	output logic [MAX_W-1:0] out_start_y,
	output logic [MAX_W-1:0] out_end_x,
	output logic [MAX_W-1:0] out_end_y,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_index,
	input  logic [MAX_W-1:0] cfg_data
);

	logic [MAX_W-1:0] clip_x_max_q, clip_y_max_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_x_max_q <= CLIP_MAX_RST;
			clip_y_max_q <= CLIP_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLIP_X_MAX: clip_x_max_q <= cfg_data;
				REG_CLIP_Y_MAX: clip_y_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline advances unless the skid holds a beat
	logic skid_vld_q, en;
	assign en         = !skid_vld_q;
	assign item_stall = skid_vld_q;

	logic      job_vld;
	clip_job_t job;

	lsrc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (item_valid && !item_stall),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.clip_x_max (clip_x_max_q),
		.clip_y_max (clip_y_max_q),
		.job_vld    (job_vld),
		.job        (job)
	);

	logic [QUO_W-1:0] q_sx, q_sy, q_ex, q_ey;

	lsrc_div u_div_sx (.clk(clk), .en(en), .op(job.sx), .quo(q_sx));
	lsrc_div u_div_sy (.clk(clk), .en(en), .op(job.sy), .quo(q_sy));
	lsrc_div u_div_ex (.clk(clk), .en(en), .op(job.ex), .quo(q_ex));
	lsrc_div u_div_ey (.clk(clk), .en(en), .op(job.ey), .quo(q_ey));

	// Valid and visible flags ride alongside the divider stages
	logic vld_s [QUO_W+1];
	logic vis_s [QUO_W+1];
	assign vld_s[0] = job_vld;
	assign vis_s[0] = job.visible;

	for (genvar i = 0; i < QUO_W; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en)
				vis_s[i+1] <= vis_s[i];
		end
	end

	// Output register plus one-beat skid
	typedef struct packed {
		logic             vis;
		logic [MAX_W-1:0] sx;
		logic [MAX_W-1:0] sy;
		logic [MAX_W-1:0] ex;
		logic [MAX_W-1:0] ey;
	} res_t;

	res_t res_d, out_q, skid_q;
	logic out_vld_q, out_free;

	assign res_d    = '{vis: vis_s[QUO_W], sx: q_sx, sy: q_sy, ex: q_ex, ey: q_ey};
	assign out_free = !out_vld_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_free) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (out_free) begin
			out_vld_q <= vld_s[QUO_W];
		end else if (vld_s[QUO_W]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_free)
				out_q <= skid_q;
		end else if (out_free) begin
			out_q <= res_d;
		end else if (vld_s[QUO_W]) begin
			skid_q <= res_d;
		end
	end

	assign res_valid   = out_vld_q;
	assign visible     = out_q.vis;
	assign out_start_x = out_q.sx;
	assign out_start_y = out_q.sy;
	assign out_end_x   = out_q.ex;
	assign out_end_y   = out_q.ey;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output register is empty");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !visible) |->
		(out_start_x == '0 && out_start_y == '0 && out_end_x == '0 && out_end_y == '0))
		else $error("rejected segment carries nonzero coordinates");

	a_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && visible) |->
		(out_start_x <= clip_x_max_q && out_end_x <= clip_x_max_q
		&& out_start_y <= clip_y_max_q && out_end_y <= clip_y_max_q))
		else $error("clipped endpoint outside rectangle");

	a_skid_from_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(res_stall && out_vld_q))
		else $error("skid filled without a stalled output");
`endif

endmodule
